// ----- src/qrp_pkg.sv -----
`default_nettype none
package qrp_pkg;
    localparam int MAX_SIDE    = 177;
    localparam int MAX_ALIGN   = 7;
    localparam int MAX_VERSION = (MAX_SIDE - 17) / 4;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SEEK  = 5'b00010,
        ST_EMIT  = 5'b00100,
        ST_SEEK2 = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // register indexes
    localparam logic [1:0] REG_VERSION = 2'd0;
    localparam logic [1:0] REG_ACOUNT  = 2'd1;
    localparam logic [1:0] REG_ACOORDS = 2'd2;

    typedef struct packed {
        logic restart;   // reset the walk
        logic step;      // advance the cursor one candidate
        logic capture;   // latch the cursor position and bit
        logic clr_res;   // clear the result register to an overflow result
        logic set_last;  // latch is_last from the full flag
    } cmd_t;

    typedef struct packed {
        logic free;
        logic full;
    } sts_t;

    typedef struct packed {
        logic [7:0] row_pos;
        logic [7:0] col_pos;
        logic       module_dark;
        logic       is_last;
        logic       overflow;
    } result_t;
endpackage
`default_nettype wire

// ----- src/qrp_stream_if.sv -----
`default_nettype none
interface qrp_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic first;
    modport source (output valid, output data_bit, output first, input ready);
    modport sink (input valid, input data_bit, input first, output ready);
endinterface

interface qrp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] row_pos;
    logic [7:0] col_pos;
    logic       module_dark;
    logic       is_last;
    logic       overflow;
    modport source (output valid, output row_pos, output col_pos, output module_dark,
                    output is_last, output overflow, input ready);
    modport sink (input valid, input row_pos, input col_pos, input module_dark,
                  input is_last, input overflow, output ready);
endinterface
`default_nettype wire

// ----- src/qrp_datapath.sv -----
`default_nettype none
module qrp_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [55:0]      cfg_data,
    input  wire qrp_pkg::cmd_t    cmd,
    input  wire logic             bit_in,
    output qrp_pkg::sts_t         sts,
    output qrp_pkg::result_t      res
);
    import qrp_pkg::*;

    logic [5:0]  version_reg;
    logic [2:0]  acount_reg;
    logic [55:0] acoords_reg;
    logic [6:0]  strip_reg;
    logic [7:0]  row_reg;
    logic        left_reg;
    logic        up_reg;
    logic        full_reg;
    result_t     res_reg;

    logic [5:0] ver;
    logic [7:0] side;
    logic [7:0] right_col;
    logic [7:0] col;
    logic       func;
    logic       occupied;
    logic [7:0] sm8;
    logic [7:0] sm11;
    logic [7:0] sm9;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            version_reg <= 6'd1;
            acount_reg  <= 3'd0;
            acoords_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_VERSION) version_reg <= cfg_data[5:0];
            if (cfg_index == REG_ACOUNT)  acount_reg  <= cfg_data[2:0];
            if (cfg_index == REG_ACOORDS) acoords_reg <= cfg_data;
        end
    end

    // effective version and side
    always_comb begin
        ver = version_reg;
        if (ver == 6'd0) ver = 6'd1;
        if (ver > 6'(MAX_VERSION)) ver = 6'(MAX_VERSION);
        side = {ver, 2'b00} + 8'd17;
        sm8  = side - 8'd8;
        sm9  = side - 8'd9;
        sm11 = side - 8'd11;
        right_col = {strip_reg, 1'b1} + ((strip_reg > 7'd2) ? 8'd1 : 8'd0);
        col = right_col - {7'd0, left_reg};
    end

    // function-module test at the cursor
    always_comb begin
        logic [7:0] x;
        logic [7:0] y;
        logic [2:0] nm1;
        occupied = 1'b0;
        nm1 = acount_reg - 3'd1;
        if (row_reg <= 8'd7 && col <= 8'd7) occupied = 1'b1;
        if (row_reg <= 8'd7 && col >= sm8) occupied = 1'b1;
        if (row_reg >= sm8 && col <= 8'd7) occupied = 1'b1;
        if (row_reg == 8'd6 || col == 8'd6) occupied = 1'b1;
        if (col == 8'd8 && (row_reg <= 8'd8 || row_reg >= sm8)) occupied = 1'b1;
        if (row_reg == 8'd8 && (col <= 8'd8 || col >= sm8)) occupied = 1'b1;
        if (ver >= 6'd7) begin
            if (row_reg >= sm11 && row_reg <= sm9 && col <= 8'd5) occupied = 1'b1;
            if (col >= sm11 && col <= sm9 && row_reg <= 8'd5) occupied = 1'b1;
        end
        for (int i = 0; i < MAX_ALIGN; i++) begin
            for (int j = 0; j < MAX_ALIGN; j++) begin
                x = acoords_reg[8*i +: 8];
                y = acoords_reg[8*j +: 8];
                if (3'(i) < acount_reg && 3'(j) < acount_reg
                    && !((i == 0 && j == 0) || (i == 0 && 3'(j) == nm1)
                         || (3'(i) == nm1 && j == 0))
                    && ({1'b0, col} + 9'd2 >= {1'b0, x})
                    && ({1'b0, col} <= {1'b0, x} + 9'd2)
                    && ({1'b0, row_reg} + 9'd2 >= {1'b0, y})
                    && ({1'b0, row_reg} <= {1'b0, y} + 9'd2))
                    occupied = 1'b1;
            end
        end
        func = occupied || row_reg >= side || col >= side;
    end

    assign sts.free = !func;
    assign sts.full = full_reg;

    // cursor walk
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            strip_reg <= 7'd9;
            row_reg   <= 8'd20;
            left_reg  <= 1'b0;
            up_reg    <= 1'b1;
            full_reg  <= 1'b0;
        end else if (cmd.restart) begin
            strip_reg <= {ver, 1'b0} + 7'd7;
            row_reg   <= side - 8'd1;
            left_reg  <= 1'b0;
            up_reg    <= 1'b1;
            full_reg  <= 1'b0;
        end else if (cmd.step) begin
            if (!left_reg) begin
                left_reg <= 1'b1;
            end else begin
                left_reg <= 1'b0;
                if (up_reg && row_reg != 8'd0) begin
                    row_reg <= row_reg - 8'd1;
                end else if (!up_reg && row_reg + 8'd1 < side) begin
                    row_reg <= row_reg + 8'd1;
                end else if (strip_reg == 7'd0) begin
                    full_reg <= 1'b1;
                end else begin
                    strip_reg <= strip_reg - 7'd1;
                    up_reg    <= ~strip_reg[0];
                    row_reg   <= strip_reg[0] ? 8'd0 : side - 8'd1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk) begin
        if (cmd.clr_res) begin
            res_reg <= '{row_pos: 8'd0, col_pos: 8'd0, module_dark: 1'b0,
                         is_last: 1'b0, overflow: 1'b1};
        end else if (cmd.capture) begin
            res_reg <= '{row_pos: row_reg, col_pos: col, module_dark: bit_in,
                         is_last: 1'b0, overflow: 1'b0};
        end else if (cmd.set_last) begin
            res_reg.is_last <= full_reg;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

// ----- src/qrp_control.sv -----
`default_nettype none
module qrp_control (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_first,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire qrp_pkg::sts_t sts,
    output qrp_pkg::cmd_t      cmd,
    output logic               first_seen
);
    import qrp_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   first_reg;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_OUT);
    assign first_seen = first_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_ready && in_valid) first_reg <= in_first;
        end
    end

    // sequencing: restart, seek, capture, advance, seek, emit; a full symbol emits overflow
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.restart = in_first;
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK: begin
                if (sts.full) begin
                    cmd.clr_res = 1'b1;
                    state_next = ST_OUT;
                end else if (sts.free) begin
                    cmd.capture = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                cmd.step = 1'b1;
                state_next = ST_SEEK2;
            end
            ST_SEEK2: begin
                if (sts.full || sts.free) begin
                    cmd.set_last = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/qr_data_module_placer_unit.sv -----
`default_nettype none
// QR data-module placer. Each input beat carries one codeword bit; one result
// beat returns its row and column in the QR zigzag, its colour, an is_last flag
// on the final free module and an overflow flag once the symbol is full.
// A placed bit passes through accept, seek, capture, advance, a second seek and
// the result. The cursor steps one candidate per cycle through a single
// function-module test, so each function module that it skips before or after
// the bit lengthens a seek. A bit dropped as overflow goes from the seek
// straight to the result. A stalled result holds off the next input.
// Configure only while idle.
module qr_data_module_placer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [55:0] cfg_data,
    qrp_in_if.sink           in_ch,
    qrp_out_if.source        out_ch
);
    import qrp_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    result_t res;
    logic    first_seen;

    qrp_control u_ctrl (
        .clk, .rst_n,
        .in_valid  (in_ch.valid),
        .in_first  (in_ch.first),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts, .cmd, .first_seen
    );

    logic bit_reg;
    always_ff @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) bit_reg <= in_ch.data_bit;
    end

    qrp_datapath u_dp (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .cmd, .bit_in(bit_reg), .sts, .res
    );

    assign out_ch.row_pos     = res.row_pos;
    assign out_ch.col_pos     = res.col_pos;
    assign out_ch.module_dark = res.module_dark;
    assign out_ch.is_last     = res.is_last;
    assign out_ch.overflow    = res.overflow;

    // never accept while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready during output");
    // overflow results carry no position
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.overflow) |-> (out_ch.row_pos == 8'd0 && !out_ch.is_last))
        else $error("overflow with data");
    // only one command at a time
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.step, cmd.capture, cmd.clr_res, cmd.set_last}))
        else $error("command clash");
    // restart implies first seen
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.restart |=> first_seen) else $error("restart without first");
endmodule
`default_nettype wire

// ----- sim/qrp_placement_checker.sv -----
module qrp_placement_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [55:0] cfg_data,
    qrp_in_if.sink           in_mon,
    qrp_out_if.sink          out_mon,
    output int               fail_count,
    output int               pending_count,
    output int               placed_count,
    output int               overflow_count,
    output int               last_count
);
    import qrp_pkg::*;

    // shadow configuration
    logic [5:0]  version_q;
    logic [2:0]  acount_q;
    logic [55:0] acoords_q;

    // shadow walk state
    int   strip_q;
    int   row_q;
    bit   left_q;
    bit   up_q;
    bit   full_q;

    result_t placements_q[$];

    function automatic int eff_ver();
        int v;
        v = version_q;
        if (v < 1) v = 1;
        if (v > MAX_VERSION) v = MAX_VERSION;
        return v;
    endfunction

    function automatic int side_of();
        return eff_ver() * 4 + 17;
    endfunction

    // function-module test for one position
    function automatic bit is_reserved(int r, int c, int s);
        int n;
        int x;
        int y;
        n = (acount_q > MAX_ALIGN) ? MAX_ALIGN : acount_q;
        if (r <= 7 && c <= 7) return 1;
        if (r <= 7 && c >= s - 8) return 1;
        if (r >= s - 8 && c <= 7) return 1;
        if (r == 6 || c == 6) return 1;
        if (c == 8 && (r <= 8 || r >= s - 8)) return 1;
        if (r == 8 && (c <= 8 || c >= s - 8)) return 1;
        if (eff_ver() >= 7) begin
            if (r >= s - 11 && r <= s - 9 && c <= 5) return 1;
            if (c >= s - 11 && c <= s - 9 && r <= 5) return 1;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if ((i == 0 && j == 0) || (i == 0 && j == n - 1) || (i == n - 1 && j == 0))
                    continue;
                x = acoords_q[8*i +: 8];
                y = acoords_q[8*j +: 8];
                if (c + 2 >= x && c <= x + 2 && r + 2 >= y && r <= y + 2) return 1;
            end
        end
        return 0;
    endfunction

    function automatic int cur_col();
        return strip_q * 2 + 1 + ((strip_q > 2) ? 1 : 0) - left_q;
    endfunction

    function automatic bit cur_free(int s);
        if (row_q >= s || cur_col() >= s) return 0;
        return !is_reserved(row_q, cur_col(), s);
    endfunction

    task automatic restart_walk();
        strip_q = eff_ver() * 2 + 7;
        row_q   = side_of() - 1;
        left_q  = 0;
        up_q    = 1;
        full_q  = 0;
    endtask

    task automatic step_cursor(int s);
        if (!left_q) begin
            left_q = 1;
            return;
        end
        left_q = 0;
        if (up_q && row_q > 0) begin
            row_q--;
            return;
        end
        if (!up_q && row_q + 1 < s) begin
            row_q++;
            return;
        end
        if (strip_q == 0) begin
            full_q = 1;
            return;
        end
        strip_q--;
        up_q  = strip_q[0];
        row_q = up_q ? s - 1 : 0;
    endtask

    task automatic seek_free(int s);
        while (!full_q && !cur_free(s)) step_cursor(s);
    endtask

    // predict the placement of one bit
    task automatic place_bit(bit dbit, bit restart);
        result_t res;
        int s;
        s = side_of();
        res = '0;
        if (restart) restart_walk();
        if (!full_q) seek_free(s);
        if (full_q) begin
            res.overflow = 1;
        end
        else begin
            res.row_pos     = row_q[7:0];
            res.col_pos     = 8'(cur_col());
            res.module_dark = dbit;
            step_cursor(s);
            seek_free(s);
            res.is_last = full_q;
        end
        placements_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            version_q = 1;
            acount_q  = 0;
            acoords_q = '0;
            restart_walk();
            placements_q.delete();
            fail_count     <= 0;
            placed_count   <= 0;
            overflow_count <= 0;
            last_count     <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == REG_VERSION) version_q = cfg_data[5:0];
                else if (cfg_index == REG_ACOUNT) acount_q = cfg_data[2:0];
                else if (cfg_index == REG_ACOORDS) acoords_q = cfg_data;
            end
            // result beat compare
            if (out_mon.valid && out_mon.ready)
            begin
                if (placements_q.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = placements_q.pop_front();
                    if (exp_r.row_pos !== out_mon.row_pos ||
                        exp_r.col_pos !== out_mon.col_pos ||
                        exp_r.module_dark !== out_mon.module_dark ||
                        exp_r.is_last !== out_mon.is_last ||
                        exp_r.overflow !== out_mon.overflow)
                        fail_count <= fail_count + 1;
                    if (exp_r.row_pos !== out_mon.row_pos)
                        $error("row_pos exp %0d got %0d", exp_r.row_pos, out_mon.row_pos);
                    if (exp_r.col_pos !== out_mon.col_pos)
                        $error("col_pos exp %0d got %0d", exp_r.col_pos, out_mon.col_pos);
                    if (exp_r.module_dark !== out_mon.module_dark)
                        $error("module_dark exp %0b got %0b", exp_r.module_dark,
                               out_mon.module_dark);
                    if (exp_r.is_last !== out_mon.is_last)
                        $error("is_last exp %0b got %0b", exp_r.is_last, out_mon.is_last);
                    if (exp_r.overflow !== out_mon.overflow)
                        $error("overflow exp %0b got %0b", exp_r.overflow, out_mon.overflow);
                    if (exp_r.overflow) overflow_count <= overflow_count + 1;
                    else placed_count <= placed_count + 1;
                    if (exp_r.is_last) last_count <= last_count + 1;
                end
            end
            // input beat predict
            if (in_mon.valid && in_mon.ready)
                place_bit(in_mon.data_bit, in_mon.first);
        end
        pending_count <= placements_q.size();
    end
endmodule

// ----- sim/tb_qr_data_module_placer_unit.sv -----
module tb_qr_data_module_placer_unit;
    import qrp_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [55:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          placed_count;
    int          overflow_count;
    int          last_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    int          beats_sent;

    qrp_in_if  in_ch ();
    qrp_out_if out_ch ();

    qr_data_module_placer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    qrp_placement_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .placed_count   (placed_count),
        .overflow_count (overflow_count),
        .last_count     (last_count)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // timeout
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial out_ch.ready = 0;
    always @(posedge clk)
    begin
        if (!rst_n) out_ch.ready <= 0;
        else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [1:0] idx, logic [55:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 0;
    endtask

    // drive one input beat, wait for acceptance
    task automatic send_bit(bit dbit, bit restart);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_ch.valid    <= 1;
        in_ch.data_bit <= dbit;
        in_ch.first    <= restart;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(int ver, int cnt, logic [55:0] coords);
        write_reg(REG_VERSION, 56'(ver));
        write_reg(REG_ACOUNT, 56'(cnt));
        write_reg(REG_ACOORDS, coords);
    endtask

    // alignment coordinates for a version, evenly spread
    function automatic logic [55:0] std_coords(int ver, output int cnt);
        logic [55:0] c;
        int s;
        int last;
        int stp;
        c = '0;
        s = ver * 4 + 17;
        cnt = (ver < 2) ? 0 : ver / 7 + 2;
        if (cnt > 7) cnt = 7;
        last = s - 7;
        stp = (cnt > 1) ? (last - 6) / (cnt - 1) : 0;
        for (int k = 0; k < cnt; k++)
            c[8*k +: 8] = (k == cnt - 1) ? 8'(last) : 8'(6 + k * stp);
        return c;
    endfunction

    initial
    begin
        int cnt;
        int ver;
        int n;
        logic [55:0] co;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_VERSION;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.data_bit = 0;
        in_ch.first = 0;
        hold_off = 0;
        beats_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset config, both bit values, restart
        send_bit(1, 0);
        send_bit(0, 0);
        send_bit(1, 1);
        send_bit(0, 0);
        drain();
        // version 1 fully filled, then overflow
        send_bit(1, 1);
        for (int k = 0; k < 207; k++) send_bit(k[0], 0);
        send_bit(1, 0);
        send_bit(0, 0);
        drain();
        // out-of-range version codes and saturated coordinates
        set_config(0, 7, {56{1'b1}});
        send_bit(1, 1);
        send_bit(0, 0);
        drain();
        set_config(63, 7, std_coords(40, cnt));
        send_bit(1, 1);
        send_bit(1, 0);
        drain();
        // config change mid-symbol keeps the cursor
        set_config(1, 0, '0);
        send_bit(1, 1);
        send_bit(0, 0);
        drain();
        set_config(7, 3, std_coords(7, cnt));
        send_bit(1, 0);
        send_bit(0, 0);
        drain();

        // random phases with varying idle profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 75 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 27 : 0;
            for (int g = 0; g < 3; g++)
            begin
                ver = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(1, 4);
                co = std_coords((ver < 1) ? 1 : (ver > 40 ? 40 : ver), cnt);
                if ($urandom_range(4) == 0)
                begin
                    co = 56'({$urandom, $urandom});
                    cnt = $urandom_range(7);
                end
                set_config(ver, cnt, co);
                // smallest symbol gets enough bits to run into overflow
                n = (ver <= 1) ? 230 : 80;
                send_bit(1'($urandom_range(1)), 1);
                for (int k = 0; k < n; k++)
                    send_bit(1'($urandom_range(1)), $urandom_range(199) == 0);
                drain();
            end
        end

        // long receiver hold-off while the sender keeps pushing
        set_config(2, 2, std_coords(2, cnt));
        fork
            begin
                hold_off <= 1;
                repeat (300) @(posedge clk);
                hold_off <= 0;
            end
            for (int k = 0; k < 30; k++) send_bit(1'($urandom_range(1)), k == 0);
        join
        drain();

        $display("Sent %0d bits: %0d placed, %0d overflow, %0d symbol ends.",
                 beats_sent, placed_count, overflow_count, last_count);
        $display("Versions 0..63 codes, alignment sets up to seven, mixed stalls covered.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
